// ===== src/frustum_bounds_cull_test_core_assert.svh =====
// Assertion macros shared by the frustum cull test RTL.
`ifndef FRUSTUM_BOUNDS_CULL_TEST_CORE_ASSERT_SVH
`define FRUSTUM_BOUNDS_CULL_TEST_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FBCT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication, checked outside reset.
`define FBCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

// ===== src/fbct_pkg.sv =====
// Shared types, widths and codes for the frustum cull test block.
package fbct_pkg;

    localparam int COORD_W    = 16;
    localparam int LEN_W      = 15;
    localparam int COEF_W     = 16;
    localparam int FRAC_BITS  = 14;
    localparam int PLANE_REGS = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int DEFAULT_PLANE_COUNT = 6;

    // dot product: three 32-bit products summed -> 34 bits, shifted by 14, plus D
    localparam int DOT_W  = 2 * COORD_W + 2;
    localparam int DIST_W = DOT_W - FRAC_BITS + 1;
    // projected radius: three 31-bit products summed -> 33 bits, shifted by 14
    localparam int PRAD_W = COEF_W + LEN_W + 2;
    localparam int RAD_W  = PRAD_W - FRAC_BITS;

    localparam logic [1:0] CONT_OUTSIDE   = 2'd0;
    localparam logic [1:0] CONT_INTERSECT = 2'd1;
    localparam logic [1:0] CONT_INSIDE    = 2'd2;

    // One plane register: A in the low 16 bits, D in the high 16 bits.
    typedef struct packed {
        logic signed [COEF_W-1:0]  d;
        logic signed [COEF_W-1:0]  c;
        logic signed [COEF_W-1:0]  b;
        logic signed [COEF_W-1:0]  a;
    } t_plane;

    // One input transaction.
    typedef struct packed {
        logic                      mode;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_z;
        logic [LEN_W-1:0]          sphere_radius;
        logic [LEN_W-1:0]          extent_x;
        logic [LEN_W-1:0]          extent_y;
        logic [LEN_W-1:0]          extent_z;
    } t_item;

    // Per-plane registered distance and radius.
    typedef struct packed {
        logic signed [DIST_W-1:0]  dist_val;
        logic [RAD_W-1:0]          rad;
    } t_lane_res;

endpackage

// ===== src/fbct_plane_regs.sv =====
// Frustum plane configuration registers with a plain write port.
module fbct_plane_regs
    import fbct_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_plane                o_planes [PLANE_REGS]
);

    t_plane r_planes [PLANE_REGS];

    // Write the addressed plane; indices past the last plane are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PLANE_REGS; i++) begin
                r_planes[i] <= '0;
            end
        end else if (i_cfg_we) begin
            for (int i = 0; i < PLANE_REGS; i++) begin
                if (i_cfg_idx == CFG_IDX_W'(i)) begin
                    r_planes[i] <= t_plane'(i_cfg_data);
                end
            end
        end
    end

    assign o_planes = r_planes;

endmodule

// ===== src/fbct_plane_lane.sv =====
// One plane lane: signed center distance and projected radius, registered.
module fbct_plane_lane
    import fbct_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_en,
    input  t_plane    i_plane,
    input  t_item     i_item,
    output t_lane_res o_res
);

    logic signed [2*COORD_W-1:0]  prod_x, prod_y, prod_z;
    logic signed [DOT_W-1:0]      dot;
    logic signed [DIST_W-2:0]     dot_floor;
    logic signed [DIST_W-1:0]     n_dist;
    logic [COEF_W-1:0]            abs_a, abs_b, abs_c;
    logic [COEF_W+LEN_W-1:0]      pr_x, pr_y, pr_z;
    logic [PRAD_W-1:0]            prad;
    logic [RAD_W-1:0]             n_rad;
    t_lane_res                    r_res;

    // Center distance: floor of the Q1.14 dot product, plus the offset.
    assign prod_x    = i_plane.a * i_item.center_x;
    assign prod_y    = i_plane.b * i_item.center_y;
    assign prod_z    = i_plane.c * i_item.center_z;
    assign dot       = {{2{prod_x[2*COORD_W-1]}}, prod_x}
                     + {{2{prod_y[2*COORD_W-1]}}, prod_y}
                     + {{2{prod_z[2*COORD_W-1]}}, prod_z};
    assign dot_floor = dot[DOT_W-1:FRAC_BITS];
    assign n_dist    = {dot_floor[DIST_W-2], dot_floor}
                     + {{(DIST_W-COEF_W){i_plane.d[COEF_W-1]}}, i_plane.d};

    // Box radius projected on the normal; the most negative code maps to 2^15.
    assign abs_a = i_plane.a[COEF_W-1] ? COEF_W'(-i_plane.a) : i_plane.a;
    assign abs_b = i_plane.b[COEF_W-1] ? COEF_W'(-i_plane.b) : i_plane.b;
    assign abs_c = i_plane.c[COEF_W-1] ? COEF_W'(-i_plane.c) : i_plane.c;
    assign pr_x  = abs_a * i_item.extent_x;
    assign pr_y  = abs_b * i_item.extent_y;
    assign pr_z  = abs_c * i_item.extent_z;
    assign prad  = {2'b00, pr_x} + {2'b00, pr_y} + {2'b00, pr_z};
    assign n_rad = i_item.mode ? prad[PRAD_W-1:FRAC_BITS]
                               : {{(RAD_W-LEN_W){1'b0}}, i_item.sphere_radius};

    // Advance with the pipeline.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res.dist_val <= n_dist;
            r_res.rad      <= n_rad;
        end
    end

    assign o_res = r_res;

endmodule

// ===== src/frustum_bounds_cull_test_core.sv =====
// Top level of the frustum cull test: input register, plane lanes, result register.
`include "frustum_bounds_cull_test_core_assert.svh"

// Tests one sphere or axis-aligned box per transaction against up to six
// frustum planes written through the configuration port (index 0..5: left,
// right, bottom, top, near, far; each A,B,C in Q1.14 and D packed 16 bits
// apiece, A lowest). A new transaction is taken every cycle while the result
// slot is free or being taken; it passes through the input register, plane
// lane register and result register, and the whole pipeline holds while the
// result waits on i_ready.
// All planes in use are evaluated in parallel, one lane of multipliers per plane.
// Write the planes only while the pipeline is empty.
module frustum_bounds_cull_test_core
    import fbct_pkg::*;
#(
    parameter int PLANE_COUNT = DEFAULT_PLANE_COUNT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    // input channel
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_mode,
    input  logic signed [COORD_W-1:0] i_center_x,
    input  logic signed [COORD_W-1:0] i_center_y,
    input  logic signed [COORD_W-1:0] i_center_z,
    input  logic [LEN_W-1:0]          i_sphere_radius,
    input  logic [LEN_W-1:0]          i_extent_x,
    input  logic [LEN_W-1:0]          i_extent_y,
    input  logic [LEN_W-1:0]          i_extent_z,
    // result channel
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_visible,
    output logic [1:0]                o_containment
);

    localparam int LANES = (PLANE_COUNT < PLANE_REGS) ? PLANE_COUNT : PLANE_REGS;

    t_plane      planes [PLANE_REGS];
    t_lane_res   lane_res [LANES];
    t_item       in_item;
    t_item       r_s1_item;
    logic        r_s1_valid;
    logic        r_s2_valid;
    logic        r_s2_mode;
    logic        r_out_valid;
    logic        r_out_visible;
    logic [1:0]  r_out_containment;
    logic        en;
    logic        any_outside;
    logic        any_touch;
    logic [1:0]  n_containment;

    // Whole pipeline advances whenever the result slot is free or being taken.
    assign en      = !r_out_valid || i_ready;
    assign o_ready = en;

    assign in_item = '{
        mode:          i_mode,
        center_x:      i_center_x,
        center_y:      i_center_y,
        center_z:      i_center_z,
        sphere_radius: i_sphere_radius,
        extent_x:      i_extent_x,
        extent_y:      i_extent_y,
        extent_z:      i_extent_z
    };

    fbct_plane_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_planes   (planes)
    );

    // Valid bits through the three stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid  <= i_valid;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    // Capture the input transaction and carry the mode alongside the lanes.
    always_ff @(posedge i_clk) begin
        if (en && i_valid) begin
            r_s1_item <= in_item;
        end
        if (en) begin
            r_s2_mode <= r_s1_item.mode;
        end
    end

    // One lane per plane in use.
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        fbct_plane_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_plane (planes[g]),
            .i_item  (r_s1_item),
            .o_res   (lane_res[g])
        );
    end

    // Reduce the per-plane compares: reject if dist < -rad, touch if dist <= rad.
    always_comb begin
        logic signed [DIST_W:0] dist_x;
        logic signed [DIST_W:0] rad_x;
        any_outside = 1'b0;
        any_touch   = 1'b0;
        for (int i = 0; i < LANES; i++) begin
            dist_x = {lane_res[i].dist_val[DIST_W-1], lane_res[i].dist_val};
            rad_x  = $signed({{(DIST_W+1-RAD_W){1'b0}}, lane_res[i].rad});
            if (dist_x < -rad_x) begin
                any_outside = 1'b1;
            end
            if (dist_x <= rad_x) begin
                any_touch = 1'b1;
            end
        end
        if (any_outside) begin
            n_containment = CONT_OUTSIDE;
        end else if (r_s2_mode && any_touch) begin
            n_containment = CONT_INTERSECT;
        end else begin
            n_containment = CONT_INSIDE;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_visible     <= !any_outside;
            r_out_containment <= n_containment;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_visible     = r_out_visible;
    assign o_containment = r_out_containment;

    // An accepted transaction always lands in the input register.
    `FBCT_ASSERT_NEXT(a_accept_lands, i_clk, i_rst_n, i_valid && o_ready, r_s1_valid)
    // A sphere never reports intersecting.
    `FBCT_ASSERT_NEXT(a_sphere_no_isect, i_clk, i_rst_n, en && r_s2_valid && !r_s2_mode, r_out_containment != CONT_INTERSECT)
    // Visible matches a non-outside containment.
    `FBCT_ASSERT_IMPLY(a_visible_match, i_clk, i_rst_n, o_valid, o_visible == (o_containment != CONT_OUTSIDE))

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for frustum_bounds_cull_test_core: predicted cull results per transaction.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fbct_pkg::*;

    localparam int HALF_PERIOD    = 4;
    localparam int RESET_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int MAX_REPORTS    = 50;
    localparam int LANES = (DEFAULT_PLANE_COUNT < PLANE_REGS) ? DEFAULT_PLANE_COUNT : PLANE_REGS;
    localparam int ONE_Q14 = 1 << FRAC_BITS;
    // squared length of a unit normal in Q1.14
    localparam int UNIT_SQ = ONE_Q14 * ONE_Q14;

    localparam logic MODE_SPHERE = 1'b0;
    localparam logic MODE_BOX    = 1'b1;

    localparam logic [CFG_IDX_W-1:0] IDX_LEFT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] IDX_RIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] IDX_BOTTOM   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] IDX_TOP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] IDX_NEAR     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] IDX_FAR      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

    typedef struct packed {
        logic       visible;
        logic [1:0] containment;
    } t_cull_result;

    typedef enum int {
        SHAPE_BOX,
        SHAPE_TILTED,
        SHAPE_RAW
    } t_frustum_shape;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [CFG_IDX_W-1:0]      i_cfg_idx;
    logic [CFG_DATA_W-1:0]     i_cfg_data;
    logic                      i_valid;
    logic                      o_ready;
    logic                      i_mode;
    logic signed [COORD_W-1:0] i_center_x;
    logic signed [COORD_W-1:0] i_center_y;
    logic signed [COORD_W-1:0] i_center_z;
    logic [LEN_W-1:0]          i_sphere_radius;
    logic [LEN_W-1:0]          i_extent_x;
    logic [LEN_W-1:0]          i_extent_y;
    logic [LEN_W-1:0]          i_extent_z;
    logic                      o_valid;
    logic                      i_ready;
    logic                      o_visible;
    logic [1:0]                o_containment;

    // predictor copy of the plane registers and the planes staged for the next load
    t_plane       plane_cfg [PLANE_REGS];
    t_plane       plane_next [PLANE_REGS];
    t_cull_result pending_cull [$];
    t_cull_result oldest_cull;
    int           send_idle_pct;
    int           ready_stall_pct;
    int           error_count;
    int           results_seen;
    int           idle_cycles;

    frustum_bounds_cull_test_core #(
        .PLANE_COUNT(DEFAULT_PLANE_COUNT)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_mode         (i_mode),
        .i_center_x     (i_center_x),
        .i_center_y     (i_center_y),
        .i_center_z     (i_center_z),
        .i_sphere_radius(i_sphere_radius),
        .i_extent_x     (i_extent_x),
        .i_extent_y     (i_extent_y),
        .i_extent_z     (i_extent_z),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_visible      (o_visible),
        .o_containment  (o_containment)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Stall the result channel at the current rate
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= ready_stall_pct);
    end

    // Cull one volume against the planes: any plane past -rad rejects it,
    // any plane within +-rad makes a box intersecting.
    function automatic t_cull_result predict_cull(input t_item vol);
        t_cull_result res;
        longint a, b, c, d, x, y, z, dist_val, rad;
        bit culled;
        bit touched;
        x = vol.center_x;
        y = vol.center_y;
        z = vol.center_z;
        culled = 1'b0;
        touched = 1'b0;
        for (int i = 0; i < LANES && !culled; i++) begin
            a = plane_cfg[i].a;
            b = plane_cfg[i].b;
            c = plane_cfg[i].c;
            d = plane_cfg[i].d;
            dist_val = ((a * x + b * y + c * z) >>> FRAC_BITS) + d;
            if (vol.mode == MODE_BOX)
                rad = (((a < 0) ? -a : a) * longint'(vol.extent_x)
                     + ((b < 0) ? -b : b) * longint'(vol.extent_y)
                     + ((c < 0) ? -c : c) * longint'(vol.extent_z)) >>> FRAC_BITS;
            else
                rad = longint'(vol.sphere_radius);
            if (dist_val < -rad)
                culled = 1'b1;
            else if (dist_val <= rad)
                touched = 1'b1;
        end
        if (culled) begin
            res.visible = 1'b0;
            res.containment = CONT_OUTSIDE;
        end else begin
            res.visible = 1'b1;
            res.containment = (vol.mode == MODE_BOX && touched) ? CONT_INTERSECT : CONT_INSIDE;
        end
        return res;
    endfunction

    function automatic t_plane make_plane(input int a, input int b, input int c, input int d);
        t_plane p;
        p.a = COEF_W'(a);
        p.b = COEF_W'(b);
        p.c = COEF_W'(c);
        p.d = COEF_W'(d);
        return p;
    endfunction

    function automatic t_item make_volume(input logic mode, input int x, input int y,
                                          input int z, input int r, input int ex,
                                          input int ey, input int ez);
        t_item vol;
        vol.mode = mode;
        vol.center_x = COORD_W'(x);
        vol.center_y = COORD_W'(y);
        vol.center_z = COORD_W'(z);
        vol.sphere_radius = LEN_W'(r);
        vol.extent_x = LEN_W'(ex);
        vol.extent_y = LEN_W'(ey);
        vol.extent_z = LEN_W'(ez);
        return vol;
    endfunction

    function automatic int rand_span(input int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    // Volume near the frustum: center within span, sizes up to size_max
    function automatic t_item random_volume(input int span, input int size_max);
        return make_volume(1'($urandom_range(1)), rand_span(span), rand_span(span),
                           rand_span(span), $urandom_range(size_max),
                           $urandom_range(size_max), $urandom_range(size_max),
                           $urandom_range(size_max));
    endfunction

    // Every field bit random
    function automatic t_item random_raw_volume();
        t_item vol;
        vol.mode = 1'($urandom);
        vol.center_x = COORD_W'($urandom);
        vol.center_y = COORD_W'($urandom);
        vol.center_z = COORD_W'($urandom);
        vol.sphere_radius = LEN_W'($urandom);
        vol.extent_x = LEN_W'($urandom);
        vol.extent_y = LEN_W'($urandom);
        vol.extent_z = LEN_W'($urandom);
        return vol;
    endfunction

    task automatic report_mismatch(input string what);
        if (error_count < MAX_REPORTS)
            $display("[%0t] result %0d: %s", $realtime, results_seen, what);
        error_count++;
    endtask

    // Drive one transaction, idling first at the current rate, and hold it until taken
    task automatic send_volume(input t_item vol);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= vol.mode;
        i_center_x <= vol.center_x;
        i_center_y <= vol.center_y;
        i_center_z <= vol.center_z;
        i_sphere_radius <= vol.sphere_radius;
        i_extent_x <= vol.extent_x;
        i_extent_y <= vol.extent_y;
        i_extent_z <= vol.extent_z;
        do @(posedge i_clk); while (!o_ready);
        pending_cull.push_back(predict_cull(vol));
    endtask

    // Drop valid and wait for every outstanding result
    task automatic settle_pipeline();
        i_valid <= 1'b0;
        while (pending_cull.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx < PLANE_REGS)
            plane_cfg[idx] = data;
        @(posedge i_clk);
    endtask

    task automatic load_planes();
        settle_pipeline();
        for (int i = 0; i < PLANE_REGS; i++)
            write_reg(IDX_LEFT + CFG_IDX_W'(i), plane_next[i]);
    endtask

    // Axis-aligned box frustum around the origin with unit normals
    task automatic stage_axis_frustum(input int wx, input int wy, input int wz);
        plane_next[IDX_LEFT]   = make_plane(ONE_Q14, 0, 0, wx);
        plane_next[IDX_RIGHT]  = make_plane(-ONE_Q14, 0, 0, wx);
        plane_next[IDX_BOTTOM] = make_plane(0, ONE_Q14, 0, wy);
        plane_next[IDX_TOP]    = make_plane(0, -ONE_Q14, 0, wy);
        plane_next[IDX_NEAR]   = make_plane(0, 0, ONE_Q14, wz);
        plane_next[IDX_FAR]    = make_plane(0, 0, -ONE_Q14, wz);
    endtask

    // Stage a random plane set of the given shape and the stimulus range suited to it
    task automatic stage_random_planes(input t_frustum_shape shape, output int span,
                                       output int size_max);
        int wx, wy, wz, widest, a, b, c, k;
        case (shape)
            SHAPE_BOX: begin
                wx = $urandom_range(12000, 200);
                wy = $urandom_range(12000, 200);
                wz = $urandom_range(12000, 200);
                widest = (wx > wy) ? wx : wy;
                widest = (wz > widest) ? wz : widest;
                stage_axis_frustum(wx, wy, wz);
                span = widest + widest / 4;
                size_max = widest / 3;
            end
            SHAPE_TILTED: begin
                // near-unit normals, origin inside every plane
                for (int i = 0; i < PLANE_REGS; i++) begin
                    a = rand_span(11585);
                    b = rand_span(11585);
                    c = $rtoi($sqrt(real'(UNIT_SQ) - real'(a * a + b * b)));
                    if ($urandom_range(1))
                        c = -c;
                    k = i % 3;
                    if (k == 0)
                        plane_next[i] = make_plane(a, b, c, $urandom_range(8000, 500));
                    else if (k == 1)
                        plane_next[i] = make_plane(c, a, b, $urandom_range(8000, 500));
                    else
                        plane_next[i] = make_plane(b, c, a, $urandom_range(8000, 500));
                end
                span = 10000;
                size_max = 3000;
            end
            default: begin
                for (int i = 0; i < PLANE_REGS; i++)
                    plane_next[i] = {$urandom, $urandom};
                span = 32767;
                size_max = 32767;
            end
        endcase
    endtask

    // All planes zero after reset: spheres inside, boxes touching
    task automatic test_reset_planes();
        send_volume(make_volume(MODE_SPHERE, -32768, -32768, -32768, 0, 32767, 32767, 32767));
        send_volume(make_volume(MODE_SPHERE, 32767, 32767, 32767, 32767, 0, 0, 0));
        send_volume(make_volume(MODE_BOX, -32768, 32767, -32768, 32767, 0, 0, 0));
        send_volume(make_volume(MODE_BOX, 32767, -32768, 0, 0, 32767, 32767, 32767));
    endtask

    // Boundaries of an axis box frustum: tangency, just outside, unused fields
    task automatic test_axis_frustum();
        stage_axis_frustum(1000, 1000, 1000);
        load_planes();
        send_volume(make_volume(MODE_SPHERE, 0, 0, 0, 0, 0, 0, 0));
        send_volume(make_volume(MODE_SPHERE, -1100, 0, 0, 100, 0, 0, 0));
        send_volume(make_volume(MODE_SPHERE, -1101, 0, 0, 100, 0, 0, 0));
        send_volume(make_volume(MODE_SPHERE, 1101, 0, 0, 100, 0, 0, 0));
        send_volume(make_volume(MODE_BOX, 0, 0, 0, 0, 999, 999, 999));
        send_volume(make_volume(MODE_BOX, 0, 0, 0, 0, 1000, 1000, 1000));
        send_volume(make_volume(MODE_BOX, -2000, 0, 0, 0, 999, 10, 10));
        send_volume(make_volume(MODE_BOX, -2000, 0, 0, 0, 1000, 10, 10));
        // box ignores the radius, sphere ignores the extents
        send_volume(make_volume(MODE_BOX, 0, 0, 0, 32767, 0, 0, 0));
        send_volume(make_volume(MODE_SPHERE, 0, 0, 0, 0, 32767, 32767, 32767));
        send_volume(make_volume(MODE_BOX, 0, 0, 5000, 0, 5, 5, 5));
        send_volume(make_volume(MODE_SPHERE, 0, -32768, 0, 32767, 0, 0, 0));
    endtask

    // Writes above the last plane index must leave the planes alone
    task automatic test_spare_index();
        settle_pipeline();
        write_reg(IDX_SPARE_LO, {$urandom, $urandom});
        write_reg(IDX_SPARE_HI, {CFG_DATA_W{1'b1}});
        send_volume(make_volume(MODE_SPHERE, 0, 0, 0, 0, 0, 0, 0));
        send_volume(make_volume(MODE_SPHERE, -1101, 0, 0, 100, 0, 0, 0));
    endtask

    // Coefficients at full scale and floor rounding of negative dot products
    task automatic test_extreme_planes();
        plane_next[IDX_LEFT]   = make_plane(-32768, -32768, -32768, -32768);
        plane_next[IDX_RIGHT]  = make_plane(32767, 32767, 32767, 32767);
        plane_next[IDX_BOTTOM] = make_plane(32767, -32768, 32767, 0);
        plane_next[IDX_TOP]    = make_plane(1, -1, 1, -1);
        plane_next[IDX_NEAR]   = make_plane(0, 0, 0, 32767);
        plane_next[IDX_FAR]    = make_plane(-32768, 0, 0, 32767);
        load_planes();
        send_volume(make_volume(MODE_BOX, -32768, -32768, -32768, 0, 32767, 32767, 32767));
        send_volume(make_volume(MODE_SPHERE, -32768, -32768, -32768, 32767, 0, 0, 0));
        send_volume(make_volume(MODE_BOX, 32767, 32767, 32767, 0, 0, 0, 0));
        send_volume(make_volume(MODE_SPHERE, -1, 0, 0, 0, 0, 0, 0));
        send_volume(make_volume(MODE_BOX, 1, -1, 1, 0, 1, 1, 1));
        send_volume(make_volume(MODE_SPHERE, 32767, -32768, 32767, 16384, 0, 0, 0));
    endtask

    // Random volumes against each frustum shape in turn, at one idling mix
    task automatic test_random_stream(input int idle_pct, input int stall_pct,
                                      input int count);
        int span, size_max;
        send_idle_pct = idle_pct;
        ready_stall_pct = stall_pct;
        for (int s = SHAPE_BOX; s <= SHAPE_RAW; s++) begin
            stage_random_planes(t_frustum_shape'(s), span, size_max);
            load_planes();
            for (int n = 0; n < count / 3; n++) begin
                if ($urandom_range(99) < 20)
                    send_volume(random_raw_volume());
                else
                    send_volume(random_volume(span, size_max));
            end
        end
    endtask

    // Check each result transaction against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_cull.size() == 0) begin
                report_mismatch("result with no transaction outstanding");
            end else begin
                oldest_cull = pending_cull.pop_front();
                if (o_visible !== oldest_cull.visible)
                    report_mismatch($sformatf("visible got %0b want %0b",
                                              o_visible, oldest_cull.visible));
                if (o_containment !== oldest_cull.containment)
                    report_mismatch($sformatf("containment got %0d want %0d",
                                              o_containment, oldest_cull.containment));
            end
            results_seen++;
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** frustum_bounds_cull_test_core: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        i_valid <= 1'b0;
        i_mode <= MODE_SPHERE;
        i_center_x <= '0;
        i_center_y <= '0;
        i_center_z <= '0;
        i_sphere_radius <= '0;
        i_extent_x <= '0;
        i_extent_y <= '0;
        i_extent_z <= '0;
        error_count = 0;
        results_seen = 0;
        send_idle_pct = 20;
        ready_stall_pct = 20;
        for (int i = 0; i < PLANE_REGS; i++)
            plane_cfg[i] = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_planes();
        test_axis_frustum();
        test_spare_index();
        test_extreme_planes();
        test_random_stream(30, 80, 366);
        test_random_stream(80, 30, 366);
        test_random_stream(0, 0, 366);

        // drain, then allow time for any stray result
        settle_pipeline();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("** frustum_bounds_cull_test_core: PASSED **");
        else
            $display("** frustum_bounds_cull_test_core: FAILED **");
        $finish;
    end

endmodule
